[hw/rtl/face_slope_classifier_defines.svh]
// Assertion helpers shared by the RTL. Clock i_clk, reset i_rst_n (active low).
`ifndef FACE_SLOPE_CLASSIFIER_DEFINES_SVH
`define FACE_SLOPE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define FSC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("face_slope_classifier check failed");

// Next-cycle implication, off while reset is held.
`define FSC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("face_slope_classifier check failed");

`endif

[hw/rtl/fsc_pkg.sv]
package fsc_pkg;

    localparam int FSC_FIELD_W    = 16;   // width of one coordinate field
    localparam int FSC_FACE_W     = 32;
    localparam int FSC_CFG_DATA_W = 32;
    localparam int FSC_CFG_IDX_W  = 1;

    // register indexes
    localparam logic [FSC_CFG_IDX_W-1:0] FSC_REG_COS   = 1'b0;
    localparam logic [FSC_CFG_IDX_W-1:0] FSC_REG_FLOOR = 1'b1;

    localparam int FSC_COS_W  = 16;       // Q2.14 threshold
    localparam int FSC_CSQ_W  = 31;       // |cos|^2 <= 2^30
    localparam logic signed [FSC_COS_W-1:0] FSC_COS_RESET   = 16'sd11585;
    localparam logic [FSC_CFG_DATA_W-1:0]   FSC_FLOOR_RESET = 32'd1;
    localparam logic [FSC_CSQ_W-1:0]        FSC_COS_SQ_RESET =
        FSC_CSQ_W'(11585 * 11585);

    localparam int FSC_LHS_SHIFT   = 28;  // 2 * 14 fraction bits
    localparam int FSC_CHUNK_W     = 24;  // slice of |n|^2 per partial product
    localparam int FSC_QUEUE_DEPTH = 16;

    typedef struct packed {
        logic [FSC_FACE_W-1:0]         face_index;
        logic signed [FSC_FIELD_W-1:0] v0_x;
        logic signed [FSC_FIELD_W-1:0] v0_y;
        logic signed [FSC_FIELD_W-1:0] v0_z;
        logic signed [FSC_FIELD_W-1:0] v1_x;
        logic signed [FSC_FIELD_W-1:0] v1_y;
        logic signed [FSC_FIELD_W-1:0] v1_z;
        logic signed [FSC_FIELD_W-1:0] v2_x;
        logic signed [FSC_FIELD_W-1:0] v2_y;
        logic signed [FSC_FIELD_W-1:0] v2_z;
    } t_in_item;

    typedef struct packed {
        logic [FSC_FACE_W-1:0] face_number;
        logic                  is_navigable;
        logic                  is_degenerate;
    } t_out_item;

endpackage

[hw/rtl/fsc_front.sv]
module fsc_front import fsc_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  t_in_item                  i_item,
    input  logic                      i_cfg_we,
    input  logic [FSC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [FSC_CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                      o_vld,
    output t_out_item                 o_item
);

    localparam int CB   = COORD_BITS;
    localparam int XW   = 32;              // sign-extended field, wider than CB
    localparam int EW   = CB + 1;          // edge
    localparam int PW   = 2 * EW;          // cross term
    localparam int NW   = 2 * CB + 3;      // normal component
    localparam int MW   = 2 * CB + 2;      // normal magnitude
    localparam int HW   = CB + 1;          // half of magnitude
    localparam int SQW  = 2 * MW;
    localparam int LW   = SQW + 2;         // |n|^2
    localparam int CW   = LW + FSC_CSQ_W;  // compare width
    localparam int CK   = FSC_CHUNK_W;
    localparam int K    = (LW + CK - 1) / CK;
    localparam int PPW  = CK + FSC_CSQ_W;
    localparam int NSTG = 11;
    localparam int LAST = NSTG - 1;

    // configuration
    logic signed [FSC_COS_W-1:0]  r_cos, n_cos;
    logic [FSC_CSQ_W-1:0]         r_cos_sq, n_cos_sq;
    logic [FSC_CFG_DATA_W-1:0]    r_floor, n_floor;
    logic signed [FSC_COS_W:0]    w_cx;
    logic [FSC_COS_W:0]           w_cmag;
    logic [2*FSC_COS_W+1:0]       w_csq;

    always_comb begin
        w_cx     = {i_cfg_wdata[FSC_COS_W-1], i_cfg_wdata[FSC_COS_W-1:0]};
        w_cmag   = w_cx[FSC_COS_W] ? (FSC_COS_W+1)'(-w_cx) : (FSC_COS_W+1)'(w_cx);
        w_csq    = w_cmag * w_cmag;
        n_cos    = r_cos;
        n_cos_sq = r_cos_sq;
        n_floor  = r_floor;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                FSC_REG_COS: begin
                    n_cos    = i_cfg_wdata[FSC_COS_W-1:0];
                    n_cos_sq = w_csq[FSC_CSQ_W-1:0];
                end
                FSC_REG_FLOOR: n_floor = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= FSC_COS_RESET;
            r_cos_sq <= FSC_COS_SQ_RESET;
            r_floor  <= FSC_FLOOR_RESET;
        end else begin
            r_cos    <= n_cos;
            r_cos_sq <= n_cos_sq;
            r_floor  <= n_floor;
        end
    end

    // pipeline registers
    logic [NSTG-1:0]        r_vld;
    logic [FSC_FACE_W-1:0]  r_face [NSTG];
    logic [LAST-1:4]        r_neg;
    logic [LAST:8]          r_degen;
    logic signed [CB-1:0]   r_s0_c   [9];
    logic signed [EW-1:0]   r_s1_e1  [3];
    logic signed [EW-1:0]   r_s1_e2  [3];
    logic signed [PW-1:0]   r_s2_p   [6];
    logic signed [NW-1:0]   r_s3_n   [3];
    logic [HW-1:0]          r_s4_hi  [3];
    logic [HW-1:0]          r_s4_lo  [3];
    logic [2*HW-1:0]        r_s5_hh  [3];
    logic [2*HW-1:0]        r_s5_hl  [3];
    logic [2*HW-1:0]        r_s5_ll  [3];
    logic [SQW-1:0]         r_s6_sq  [3];
    logic [LW-1:0]          r_s7_len;
    logic [SQW-1:0]         r_s7_sqy;
    logic [PPW-1:0]         r_s8_pp  [K];
    logic [SQW-1:0]         r_s8_sqy;
    logic [CW-1:0]          r_s9_lhs;
    logic [CW-1:0]          r_s9_rhs;
    logic                   r_s10_nav;

    // combinational pieces between stages
    logic [FSC_FIELD_W-1:0] w_fld  [9];
    logic [XW-1:0]          w_fx   [9];
    logic signed [CB-1:0]   w_c    [9];
    logic signed [EW-1:0]   w_cx0  [9];
    logic [NW-1:0]          w_mag  [3];
    logic [SQW-1:0]         w_sq   [3];
    logic [K*CK-1:0]        w_lpad;
    logic [CW-1:0]          w_rhs;
    logic                   w_cos_neg;
    logic                   w_cos_zero;
    logic                   w_nav;

    always_comb begin
        w_fld[0] = i_item.v0_x;  w_fld[1] = i_item.v0_y;  w_fld[2] = i_item.v0_z;
        w_fld[3] = i_item.v1_x;  w_fld[4] = i_item.v1_y;  w_fld[5] = i_item.v1_z;
        w_fld[6] = i_item.v2_x;  w_fld[7] = i_item.v2_y;  w_fld[8] = i_item.v2_z;
        for (int j = 0; j < 9; j++) begin
            w_fx[j]  = {{(XW-FSC_FIELD_W){w_fld[j][FSC_FIELD_W-1]}}, w_fld[j]};
            w_c[j]   = w_fx[j][CB-1:0];
            w_cx0[j] = {r_s0_c[j][CB-1], r_s0_c[j]};
        end
        for (int a = 0; a < 3; a++) begin
            w_mag[a] = r_s3_n[a][NW-1] ? NW'(-r_s3_n[a]) : NW'(r_s3_n[a]);
            w_sq[a]  = (SQW'(r_s5_hh[a]) << (2 * HW)) + (SQW'(r_s5_hl[a]) << (HW + 1))
                     + SQW'(r_s5_ll[a]);
        end
        w_lpad = (K*CK)'(r_s7_len);
        w_rhs  = '0;
        for (int k = 0; k < K; k++) begin
            w_rhs = w_rhs + (CW'(r_s8_pp[k]) << (k * CK));
        end
        w_cos_neg  = r_cos[FSC_COS_W-1];
        w_cos_zero = (r_cos == '0);
        if (r_neg[9]) begin
            w_nav = w_cos_neg && (r_s9_lhs <= r_s9_rhs);
        end else begin
            w_nav = w_cos_neg || w_cos_zero || (r_s9_lhs >= r_s9_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], i_accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_face[0] <= i_item.face_index;
        for (int s = 1; s < NSTG; s++) begin
            r_face[s] <= r_face[s-1];
        end
        // stage 0: coordinates at COORD_BITS
        for (int j = 0; j < 9; j++) begin
            r_s0_c[j] <= w_c[j];
        end
        // stage 1: edges from vertex 0
        for (int a = 0; a < 3; a++) begin
            r_s1_e1[a] <= w_cx0[3+a] - w_cx0[a];
            r_s1_e2[a] <= w_cx0[6+a] - w_cx0[a];
        end
        // stage 2: cross terms
        r_s2_p[0] <= r_s1_e1[1] * r_s1_e2[2];
        r_s2_p[1] <= r_s1_e1[2] * r_s1_e2[1];
        r_s2_p[2] <= r_s1_e1[2] * r_s1_e2[0];
        r_s2_p[3] <= r_s1_e1[0] * r_s1_e2[2];
        r_s2_p[4] <= r_s1_e1[0] * r_s1_e2[1];
        r_s2_p[5] <= r_s1_e1[1] * r_s1_e2[0];
        // stage 3: normal
        for (int a = 0; a < 3; a++) begin
            r_s3_n[a] <= $signed({r_s2_p[2*a][PW-1], r_s2_p[2*a]})
                       - $signed({r_s2_p[2*a+1][PW-1], r_s2_p[2*a+1]});
        end
        // stage 4: magnitudes split in halves
        for (int a = 0; a < 3; a++) begin
            r_s4_hi[a] <= w_mag[a][MW-1:HW];
            r_s4_lo[a] <= w_mag[a][HW-1:0];
        end
        r_neg[4] <= r_s3_n[1][NW-1];
        for (int s = 5; s < LAST; s++) begin
            r_neg[s] <= r_neg[s-1];
        end
        // stage 5: partial squares
        for (int a = 0; a < 3; a++) begin
            r_s5_hh[a] <= r_s4_hi[a] * r_s4_hi[a];
            r_s5_hl[a] <= r_s4_hi[a] * r_s4_lo[a];
            r_s5_ll[a] <= r_s4_lo[a] * r_s4_lo[a];
        end
        // stage 6: squares
        for (int a = 0; a < 3; a++) begin
            r_s6_sq[a] <= w_sq[a];
        end
        // stage 7: |n|^2
        r_s7_len <= LW'(r_s6_sq[0]) + LW'(r_s6_sq[1]) + LW'(r_s6_sq[2]);
        r_s7_sqy <= r_s6_sq[1];
        // stage 8: floor test, |n|^2 * cos^2 in slices
        r_degen[8] <= (r_s7_len < LW'(r_floor));
        for (int k = 0; k < K; k++) begin
            r_s8_pp[k] <= w_lpad[k*CK +: CK] * r_cos_sq;
        end
        r_s8_sqy <= r_s7_sqy;
        // stage 9: both sides of the compare
        r_s9_rhs   <= w_rhs;
        r_s9_lhs   <= CW'(r_s8_sqy) << FSC_LHS_SHIFT;
        r_degen[9] <= r_degen[8];
        // stage 10: label
        r_degen[10] <= r_degen[9];
        r_s10_nav   <= w_nav && !r_degen[9];
    end

    assign o_vld  = r_vld[LAST];
    assign o_item = '{face_number:   r_face[LAST],
                      is_navigable:  r_s10_nav,
                      is_degenerate: r_degen[LAST]};

endmodule

[hw/rtl/fsc_queue.sv]
`include "face_slope_classifier_defines.svh"

module fsc_queue import fsc_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    input  logic      i_pop,
    output logic      o_vld,
    output t_out_item o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNW = $clog2(DEPTH + 1);

    t_out_item      r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNW-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_vld  = (r_count != '0);
    assign o_head = r_mem[r_rd_ptr];

    // credit check upstream must keep the queue from overflowing
    `FSC_ASSERT_IMPL(a_no_overflow, r_count == CNW'(DEPTH), !i_push || i_pop)
    `FSC_ASSERT_IMPL(a_no_underflow, i_pop, r_count != '0)
    `FSC_ASSERT_IMPL(a_empty_ptrs, r_count == '0, r_wr_ptr == r_rd_ptr)

endmodule

[hw/rtl/fsc_back.sv]
`include "face_slope_classifier_defines.svh"

module fsc_back import fsc_pkg::*; #(
    parameter int QDEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    output logic      o_full,
    input  logic      i_q_vld,
    input  t_out_item i_q_head,
    output logic      o_q_pop,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    localparam int CAP = QDEPTH + 1;   // queue plus output register
    localparam int OW  = $clog2(CAP + 1);

    logic           r_vld, n_vld;
    t_out_item      r_item;
    logic [OW-1:0]  r_occ, n_occ;
    logic           w_deliver;

    always_comb begin
        w_deliver = i_pop && r_vld;
        o_q_pop   = i_q_vld && (!r_vld || i_pop);
        n_vld     = o_q_pop || (r_vld && !i_pop);
        n_occ     = r_occ;
        if (i_accept && !w_deliver) begin
            n_occ = r_occ + OW'(1);
        end else if (!i_accept && w_deliver) begin
            n_occ = r_occ - OW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_occ <= '0;
        end else begin
            r_vld <= n_vld;
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_head;
        end
    end

    assign o_full  = (r_occ == OW'(CAP));
    assign o_empty = !r_vld;
    assign o_item  = r_item;

    `FSC_ASSERT_IMPL(a_vld_has_credit, r_vld, r_occ != '0)
    `FSC_ASSERT_IMPL(a_degen_not_nav, r_vld && r_item.is_degenerate, !r_item.is_navigable)
    `FSC_ASSERT_NEXT(a_accept_counts, i_accept, r_occ != '0)

endmodule

[hw/rtl/face_slope_classifier.sv]
// Path: an accepted request passes the 11 arithmetic stages, the queue and the
//   output register before its result reaches the output.
// Throughput: one request per cycle while full is low, set by the fully pipelined front end.
// Reset: synchronous, active low; clears pipeline valids, queue and credit
//   count, and loads the slope threshold = 11585 (45 deg) and length floor = 1.
module face_slope_classifier import fsc_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // request side
    input  logic                      push,
    output logic                      full,
    input  t_in_item                  i_item,
    // result side
    output logic                      empty,
    input  logic                      pop,
    output t_out_item                 o_item,
    // configuration writes
    input  logic                      i_cfg_we,
    input  logic [FSC_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [FSC_CFG_DATA_W-1:0] i_cfg_wdata
);

    // Front end: edges, cross product, squared lengths and the slope test,
    // all as a fixed pipeline that never stalls. A request is admitted only
    // while the back end holds a free slot for it (credit count covers
    // every request in flight, queued or waiting at the output), so the
    // pipeline can always drop its result into the queue.
    //
    // Slope test, no root or divide:
    //   ny >= 0: navigable if cos <= 0 or ny^2 * 2^28 >= cos^2 * |n|^2
    //   ny <  0: navigable if cos <  0 and ny^2 * 2^28 <= cos^2 * |n|^2
    // and degenerate (|n|^2 < floor) is always occlusion.
    // cos^2 is formed once when the threshold register is written.

    logic       w_accept;
    logic       w_f_vld;
    t_out_item  w_f_item;
    logic       w_q_vld;
    t_out_item  w_q_head;
    logic       w_q_pop;

    assign w_accept = push && !full;

    fsc_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_vld       (w_f_vld),
        .o_item      (w_f_item)
    );

    // short queue decoupling the arithmetic from the result handshake
    fsc_queue #(
        .DEPTH (FSC_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_vld),
        .i_item  (w_f_item),
        .i_pop   (w_q_pop),
        .o_vld   (w_q_vld),
        .o_head  (w_q_head)
    );

    // output register and admission credit
    fsc_back #(
        .QDEPTH (FSC_QUEUE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .o_full   (full),
        .i_q_vld  (w_q_vld),
        .i_q_head (w_q_head),
        .o_q_pop  (w_q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_item)
    );

endmodule
